// ===== hdl/isbc_pkg.sv =====
`default_nettype none

package isbc_pkg;

    localparam int unsigned CHECK_INTERVAL = 20;
    localparam int unsigned SLEEP_DELAY    = 120;
    localparam int unsigned WAKE_HOLDOFF   = 60;
    localparam int unsigned CORNER_SIZE    = 8;

    localparam int unsigned TICK_W     = 32;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned SIZE_W     = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    typedef enum logic [1:0] {
        CMD_POLL    = 2'd0,
        CMD_EVENT   = 2'd1,
        CMD_CONTROL = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WAKE    = 2'd0,
        OP_SLEEP   = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } t_ctrl_op;

    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_TR = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_BL = 2'd3
    } t_corner;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_TICKS    = 3'd0,
        CFG_REFRESH_TICKS = 3'd1,
        CFG_SLEEP_CORNER  = 3'd2,
        CFG_WAKE_CORNER   = 3'd3,
        CFG_MENUBAR_FIX   = 3'd4,
        CFG_SCREEN_WIDTH  = 3'd5,
        CFG_SCREEN_HEIGHT = 3'd6,
        CFG_START_ENABLED = 3'd7
    } t_cfg_index;

    localparam logic [3:0] EVT_INPUT_FIRST = 4'd1;
    localparam logic [3:0] EVT_INPUT_LAST  = 4'd5;
    localparam logic [3:0] EVT_UPDATE      = 4'd7;

    typedef struct packed {
        logic [LIMIT_W-1:0] idle_ticks;
        logic [LIMIT_W-1:0] refresh_ticks;
        t_corner            sleep_corner;
        t_corner            wake_corner;
        logic               menubar_fix;
        logic [SIZE_W-1:0]  screen_width;
        logic [SIZE_W-1:0]  screen_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        idle_ticks:    31'd18000,
        refresh_ticks: 31'd1800,
        sleep_corner:  CORNER_TL,
        wake_corner:   CORNER_TR,
        menubar_fix:   1'b0,
        screen_width:  12'd640,
        screen_height: 12'd480
    };

    localparam logic START_ENABLED_RESET = 1'b1;

    typedef struct packed {
        t_cmd              cmd;
        logic [TICK_W-1:0] now;
        logic [POS_W-1:0]  mouse_x;
        logic [POS_W-1:0]  mouse_y;
        logic              menubar_visible;
        logic [3:0]        event_code;
        t_ctrl_op          control_op;
    } t_item;

    typedef struct packed {
        logic [TICK_W-1:0] last_check_time;
        logic [TICK_W-1:0] last_activity_time;
        logic [TICK_W-1:0] last_refresh_time;
        logic [POS_W-1:0]  prev_mouse_x;
        logic [POS_W-1:0]  prev_mouse_y;
        logic              in_sleep_corner;
        logic              blanked;
        logic              want_sleep;
        logic              want_wake;
        logic              enabled;
    } t_state;

    localparam t_state STATE_RESET = '{
        last_check_time:    32'd0,
        last_activity_time: 32'd0,
        last_refresh_time:  32'd0,
        prev_mouse_x:       16'd0,
        prev_mouse_y:       16'd0,
        in_sleep_corner:    1'b0,
        blanked:            1'b0,
        want_sleep:         1'b0,
        want_wake:          1'b0,
        enabled:            START_ENABLED_RESET
    };

    typedef struct packed {
        logic restore_screen;
        logic blank_screen;
        logic swallow_event;
        logic saver_enabled;
        logic screen_blanked;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/isbc_step.sv =====
`default_nettype none

module isbc_step (
    input  wire isbc_pkg::t_cfg    i_cfg,
    input  wire isbc_pkg::t_state  i_state,
    input  wire isbc_pkg::t_item   i_item,
    output isbc_pkg::t_state       o_state,
    output isbc_pkg::t_result      o_result
);

    localparam int unsigned PW = 18;

    // signed tick difference greater than an unsigned limit
    function automatic logic ticks_gt(input logic [isbc_pkg::TICK_W-1:0] diff,
                                      input logic [isbc_pkg::LIMIT_W-1:0] lim);
        logic signed [isbc_pkg::TICK_W:0] d;
        logic signed [isbc_pkg::TICK_W:0] l;
        d = $signed({diff[isbc_pkg::TICK_W-1], diff});
        l = $signed({2'b00, lim});
        return d > l;
    endfunction

    function automatic logic in_corner(input isbc_pkg::t_corner corner,
                                       input logic [isbc_pkg::POS_W-1:0] x,
                                       input logic [isbc_pkg::POS_W-1:0] y,
                                       input logic [isbc_pkg::SIZE_W-1:0] w,
                                       input logic [isbc_pkg::SIZE_W-1:0] h);
        logic signed [PW-1:0] cs;
        logic signed [PW-1:0] xe;
        logic signed [PW-1:0] ye;
        logic signed [PW-1:0] we;
        logic signed [PW-1:0] he;
        logic signed [PW-1:0] lo_x;
        logic signed [PW-1:0] hi_x;
        logic signed [PW-1:0] lo_y;
        logic signed [PW-1:0] hi_y;
        logic                 right;
        logic                 bottom;
        cs = $signed(PW'(isbc_pkg::CORNER_SIZE));
        xe = PW'($signed(x));
        ye = PW'($signed(y));
        we = $signed({{(PW-isbc_pkg::SIZE_W){1'b0}}, w});
        he = $signed({{(PW-isbc_pkg::SIZE_W){1'b0}}, h});
        right  = (corner == isbc_pkg::CORNER_TR) || (corner == isbc_pkg::CORNER_BR);
        bottom = (corner == isbc_pkg::CORNER_BR) || (corner == isbc_pkg::CORNER_BL);
        lo_x = right ? we - cs : -$signed(PW'(1));
        hi_x = right ? we : cs - $signed(PW'(1));
        lo_y = bottom ? he - cs : -$signed(PW'(1));
        hi_y = bottom ? he : cs - $signed(PW'(1));
        return (xe >= lo_x) && (xe <= hi_x) && (ye >= lo_y) && (ye <= hi_y);
    endfunction

    isbc_pkg::t_state n_state;
    logic             restore;
    logic             blank;
    logic             swallow;
    logic             moved;
    logic             in_sleep;
    logic             in_wake;
    logic             input_evt;

    always_comb begin
        n_state   = i_state;
        restore   = 1'b0;
        blank     = 1'b0;
        swallow   = 1'b0;
        moved     = (i_item.mouse_x != i_state.prev_mouse_x)
                  || (i_item.mouse_y != i_state.prev_mouse_y);
        in_sleep  = in_corner(i_cfg.sleep_corner, i_item.mouse_x, i_item.mouse_y,
                              i_cfg.screen_width, i_cfg.screen_height);
        in_wake   = in_corner(i_cfg.wake_corner, i_item.mouse_x, i_item.mouse_y,
                              i_cfg.screen_width, i_cfg.screen_height);
        input_evt = ((i_item.event_code >= isbc_pkg::EVT_INPUT_FIRST)
                  && (i_item.event_code <= isbc_pkg::EVT_INPUT_LAST))
                  || (i_item.event_code == isbc_pkg::EVT_UPDATE);

        case (i_item.cmd)
            isbc_pkg::CMD_POLL: begin
                if (ticks_gt(i_item.now - i_state.last_check_time,
                             isbc_pkg::LIMIT_W'(isbc_pkg::CHECK_INTERVAL))) begin
                    n_state.last_check_time = i_item.now;
                    if (moved) begin
                        n_state.prev_mouse_x       = i_item.mouse_x;
                        n_state.prev_mouse_y       = i_item.mouse_y;
                        n_state.last_activity_time = i_item.now;
                        n_state.in_sleep_corner    = 1'b0;
                        if (i_state.blanked) begin
                            n_state.want_wake = 1'b1;
                        end
                    end
                    if (!i_state.blanked) begin
                        if (!n_state.in_sleep_corner && in_sleep) begin
                            n_state.in_sleep_corner    = 1'b1;
                            n_state.last_activity_time = n_state.last_activity_time
                                - {1'b0, i_cfg.idle_ticks}
                                + isbc_pkg::TICK_W'(isbc_pkg::SLEEP_DELAY);
                        end else if (in_wake) begin
                            n_state.last_activity_time = i_item.now;
                        end
                        if (ticks_gt(i_item.now - n_state.last_activity_time,
                                     i_cfg.idle_ticks)) begin
                            n_state.want_sleep = 1'b1;
                        end
                    end else if (!n_state.want_wake) begin
                        if (ticks_gt(i_item.now - i_state.last_refresh_time,
                                     i_cfg.refresh_ticks)) begin
                            n_state.last_refresh_time = i_item.now;
                            n_state.want_sleep        = 1'b1;
                        end
                        if (i_cfg.menubar_fix && i_item.menubar_visible) begin
                            n_state.want_sleep = 1'b1;
                        end
                    end else begin
                        n_state.want_wake          = 1'b0;
                        n_state.blanked            = 1'b0;
                        n_state.last_activity_time = i_item.now
                            + isbc_pkg::TICK_W'(isbc_pkg::WAKE_HOLDOFF);
                        restore                    = 1'b1;
                    end
                    if (n_state.want_sleep && n_state.enabled) begin
                        n_state.blanked           = 1'b1;
                        n_state.want_sleep        = 1'b0;
                        n_state.last_refresh_time = i_item.now;
                        blank                     = 1'b1;
                    end
                end
            end
            isbc_pkg::CMD_EVENT: begin
                if (input_evt) begin
                    n_state.last_activity_time = i_item.now;
                    n_state.in_sleep_corner    = 1'b0;
                    if (i_state.blanked) begin
                        swallow           = (i_item.event_code != isbc_pkg::EVT_UPDATE);
                        n_state.want_wake = 1'b1;
                    end
                end
            end
            isbc_pkg::CMD_CONTROL: begin
                case (i_item.control_op)
                    isbc_pkg::OP_WAKE: begin
                        if (i_state.blanked) begin
                            n_state.want_wake = 1'b1;
                        end
                    end
                    isbc_pkg::OP_SLEEP: begin
                        if (i_state.enabled) begin
                            n_state.want_sleep = 1'b1;
                        end
                    end
                    isbc_pkg::OP_ENABLE: begin
                        n_state.enabled    = 1'b1;
                        n_state.want_sleep = 1'b0;
                    end
                    default: begin
                        if (i_state.blanked) begin
                            n_state.want_wake = 1'b1;
                        end
                        n_state.enabled = 1'b0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_state                 = n_state;
    assign o_result.restore_screen = restore;
    assign o_result.blank_screen   = blank;
    assign o_result.swallow_event  = swallow;
    assign o_result.saver_enabled  = n_state.enabled;
    assign o_result.screen_blanked = n_state.blanked;

endmodule

`default_nettype wire

// ===== hdl/idle_screen_blanker_control_top.sv =====
// Screen blanking controller.
// Input channel: i_in_valid / o_in_stall with one item per transfer (kind,
// tick count, mouse position, menu bar flag, event code, control op).
// Output channel: o_out_valid / i_out_stall, one result per input item,
// carrying restore, blank, swallow and the enabled / blanked status.
// Configuration: i_cfg_we writes i_cfg_data to the setting at i_cfg_index;
// the user must write only while no item is in flight; the block does not enforce it.
// Each item passes one input register, then the state update writes the
// result register.
// Throughput is one item per cycle while no result is stalled; the state
// update is a single pass of flag logic and 32-bit tick compares.
// A stalled result holds in the output register while one more item waits
// in the input register; after that o_in_stall rises.
// Synchronous reset restores the default settings, clears all times,
// mouse position and flags, and sets the saver enabled.
`default_nettype none

module idle_screen_blanker_control_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [1:0]                           i_cmd,
    input  wire  [isbc_pkg::TICK_W-1:0]          i_now,
    input  wire  signed [isbc_pkg::POS_W-1:0]    i_mouse_x,
    input  wire  signed [isbc_pkg::POS_W-1:0]    i_mouse_y,
    input  wire                                  i_menubar_visible,
    input  wire  [3:0]                           i_event_code,
    input  wire  [1:0]                           i_control_op,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_restore_screen,
    output logic                                 o_blank_screen,
    output logic                                 o_swallow_event,
    output logic                                 o_saver_enabled,
    output logic                                 o_screen_blanked,
    input  wire                                  i_cfg_we,
    input  wire  [isbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [isbc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    isbc_pkg::t_cfg    r_cfg;
    isbc_pkg::t_state  r_state;
    isbc_pkg::t_state  n_state;
    isbc_pkg::t_item   r_item;
    isbc_pkg::t_result r_result;
    isbc_pkg::t_result n_result;
    logic              r_s1_valid;
    logic              r_out_valid;
    logic              out_ready;
    logic              s1_ready;
    logic              advance;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign advance    = r_s1_valid && out_ready;
    assign o_in_stall = !s1_ready;

    isbc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cfg         <= isbc_pkg::CFG_RESET;
            r_state       <= isbc_pkg::STATE_RESET;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    isbc_pkg::CFG_IDLE_TICKS:    r_cfg.idle_ticks    <= i_cfg_data;
                    isbc_pkg::CFG_REFRESH_TICKS: r_cfg.refresh_ticks <= i_cfg_data;
                    isbc_pkg::CFG_SLEEP_CORNER:
                        r_cfg.sleep_corner <= isbc_pkg::t_corner'(i_cfg_data[1:0]);
                    isbc_pkg::CFG_WAKE_CORNER:
                        r_cfg.wake_corner <= isbc_pkg::t_corner'(i_cfg_data[1:0]);
                    isbc_pkg::CFG_MENUBAR_FIX:   r_cfg.menubar_fix   <= i_cfg_data[0];
                    isbc_pkg::CFG_SCREEN_WIDTH:
                        r_cfg.screen_width <= i_cfg_data[isbc_pkg::SIZE_W-1:0];
                    isbc_pkg::CFG_SCREEN_HEIGHT:
                        r_cfg.screen_height <= i_cfg_data[isbc_pkg::SIZE_W-1:0];
                    // start value only matters at reset, which reloads the default
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_item.cmd             <= isbc_pkg::t_cmd'(i_cmd);
            r_item.now             <= i_now;
            r_item.mouse_x         <= i_mouse_x;
            r_item.mouse_y         <= i_mouse_y;
            r_item.menubar_visible <= i_menubar_visible;
            r_item.event_code      <= i_event_code;
            r_item.control_op      <= isbc_pkg::t_ctrl_op'(i_control_op);
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_restore_screen = r_result.restore_screen;
    assign o_blank_screen   = r_result.blank_screen;
    assign o_swallow_event  = r_result.swallow_event;
    assign o_saver_enabled  = r_result.saver_enabled;
    assign o_screen_blanked = r_result.screen_blanked;

    // status in a waiting result matches the state it left behind
    a_status_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.screen_blanked == r_state.blanked)
                     && (r_result.saver_enabled == r_state.enabled))
        else $error("result status differs from controller state");

    // a blank in this step always leaves the screen blanked
    a_blank_sets_blanked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.blank_screen |-> r_result.screen_blanked)
        else $error("blank without blanked status");

    // a swallowed event always leaves a wake request pending
    a_swallow_wakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.swallow_event |-> r_state.want_wake)
        else $error("swallowed event without wake request");

    // an empty input register never stalls the sender
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled while input register empty");

endmodule

`default_nettype wire
